@@ rtl/fermion_occupation_move_engine_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the fermion occupation move engine
// Each macro expands to a clocked concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef FERMION_OCCUPATION_MOVE_ENGINE_DEFINES_SVH
`define FERMION_OCCUPATION_MOVE_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define FOME_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define FOME_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define FOME_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FOME_ASSERT_ALWAYS(lbl, prop)
`define FOME_ASSERT_IMPLIES(lbl, ante, cons)
`define FOME_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/fome_pkg.sv @@
// ----------------------------------------------------------------------------
// fome_pkg
// Shared types and codes of the fermion occupation move engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fome_pkg;

    localparam int MAX_SITES = 64;
    localparam int SITE_W    = $clog2(MAX_SITES);
    localparam int CNT_W     = $clog2(MAX_SITES + 1);
    localparam int NUM_LISTS = 4;
    localparam int PADDR_W   = 4;

    typedef logic [MAX_SITES-1:0] occ_t;
    typedef logic [SITE_W-1:0]    site_t;
    typedef logic [CNT_W-1:0]     count_t;

    // operation codes
    localparam logic [3:0] OP_CLEAR   = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_UP_HOP  = 4'd2;
    localparam logic [3:0] OP_DN_HOP  = 4'd3;
    localparam logic [3:0] OP_EXCH    = 4'd4;
    localparam logic [3:0] OP_UP_OPR  = 4'd5;
    localparam logic [3:0] OP_DN_OPR  = 4'd6;
    localparam logic [3:0] OP_EX_OPR  = 4'd7;
    localparam logic [3:0] OP_COMMIT  = 4'd8;
    localparam logic [3:0] OP_UNDO    = 4'd9;
    localparam logic [3:0] OP_QUERY   = 4'd10;

    // list selects, also list memory indexes
    localparam logic [1:0] LIST_UP_PART = 2'd0;
    localparam logic [1:0] LIST_UP_HOLE = 2'd1;
    localparam logic [1:0] LIST_DN_PART = 2'd2;
    localparam logic [1:0] LIST_DN_HOLE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SITE_COUNT = 2'd0;
    localparam logic [1:0] REG_UP_COUNT   = 2'd1;
    localparam logic [1:0] REG_DN_COUNT   = 2'd2;
    localparam logic [1:0] REG_ALLOW_DBL  = 2'd3;

    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_UP   = 2'd1,
        KIND_DN   = 2'd2,
        KIND_EX   = 2'd3
    } kind_t;

endpackage

`default_nettype wire

@@ rtl/fome_ifs.sv @@
// ----------------------------------------------------------------------------
// fome interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fome_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] operation;
    logic [5:0] up_pick;
    logic [5:0] down_pick;
    logic [5:0] hole_pick;
    logic [5:0] site_i;
    logic [5:0] site_j;
    logic [1:0] list_select;
    logic [5:0] list_index;
    logic [5:0] list_site;

    modport source (output valid, operation, up_pick, down_pick, hole_pick, site_i,
                    site_j, list_select, list_index, list_site, input ready);
    modport sink   (input valid, operation, up_pick, down_pick, hole_pick, site_i,
                    site_j, list_select, list_index, list_site, output ready);
endinterface

interface fome_out_if;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic signed [1:0] sign;
    logic signed [1:0] double_change;
    logic [6:0]        double_count;
    logic              up_occupied;
    logic              down_occupied;

    modport source (output valid, accepted, sign, double_change, double_count,
                    up_occupied, down_occupied, input ready);
    modport sink   (input valid, accepted, sign, double_change, double_count,
                    up_occupied, down_occupied, output ready);
endinterface

`default_nettype wire

@@ rtl/fome_ram.sv @@
// ----------------------------------------------------------------------------
// fome_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fome_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/fermion_occupation_move_engine.sv @@
// Steps: clear, commit, undo, query go S_START to S_DONE; hop proposals and operators
//   pass S_HOP or S_OP; load recounts doubly occupied sites in S_COUNT, 8 sites a cycle;
//   exchange searches holes in S_EXS1, S_EXS2, one list-memory read per hole entry searched.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: rst_n asynchronous, active low; occupancy, pending move and count cleared.
//   Site lists are undefined until loaded; no clearing pass.
// ----------------------------------------------------------------------------
// fermion_occupation_move_engine
// Occupation bits, site lists in RAM, pending move with undo and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fermion_occupation_move_engine_defines.svh"

module fermion_occupation_move_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fome_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    fome_in_if.sink                          req,
    fome_out_if.source                       rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_OP, S_HOP, S_EXRD, S_EXS1, S_EXS2, S_COUNT, S_DONE
    } state_t;

    // ---------------- configuration ----------------
    fome_pkg::count_t sc_reg, upc_reg, dnc_reg;
    logic             ad_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg  <= fome_pkg::count_t'(fome_pkg::MAX_SITES);
            upc_reg <= '0;
            dnc_reg <= '0;
            ad_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                fome_pkg::REG_SITE_COUNT: sc_reg  <= pwdata[6:0];
                fome_pkg::REG_UP_COUNT:   upc_reg <= pwdata[6:0];
                fome_pkg::REG_DN_COUNT:   dnc_reg <= pwdata[6:0];
                fome_pkg::REG_ALLOW_DBL:  ad_reg  <= pwdata[0];
                default:                  ad_reg  <= ad_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            fome_pkg::REG_SITE_COUNT: prdata = {25'd0, sc_reg};
            fome_pkg::REG_UP_COUNT:   prdata = {25'd0, upc_reg};
            fome_pkg::REG_DN_COUNT:   prdata = {25'd0, dnc_reg};
            fome_pkg::REG_ALLOW_DBL:  prdata = {31'd0, ad_reg};
            default:                  prdata = '0;
        endcase
    end

    // effective site, particle and hole counts
    fome_pkg::count_t n_w, uc_w, dc_w, uh_w, dh_w;
    assign n_w  = (sc_reg > fome_pkg::count_t'(fome_pkg::MAX_SITES))
                  ? fome_pkg::count_t'(fome_pkg::MAX_SITES) : sc_reg;
    assign uc_w = (upc_reg > n_w) ? n_w : upc_reg;
    assign dc_w = (dnc_reg > n_w) ? n_w : dnc_reg;
    assign uh_w = n_w - uc_w;
    assign dh_w = n_w - dc_w;

    // ---------------- state ----------------
    state_t              state_reg, state_next;
    logic [3:0]          op_reg, op_next;
    fome_pkg::site_t     upk_reg, upk_next, dpk_reg, dpk_next, hpk_reg, hpk_next;
    fome_pkg::site_t     si_reg, si_next, sj_reg, sj_next;
    logic [1:0]          sel_reg, sel_next;
    fome_pkg::site_t     lidx_reg, lidx_next, lsite_reg, lsite_next;
    fome_pkg::occ_t      up_reg, up_next, dn_reg, dn_next;
    fome_pkg::kind_t     kind_reg, kind_next;
    fome_pkg::site_t     ms_reg [4];
    fome_pkg::site_t     ms_next [4];
    fome_pkg::site_t     mi_reg [4];
    fome_pkg::site_t     mi_next [4];
    logic signed [1:0]   pdc_reg, pdc_next;
    logic [6:0]          dtot_reg, dtot_next;
    logic                acc_reg, acc_next;
    logic signed [1:0]   sign_reg, sign_next;
    fome_pkg::site_t     ufr_reg, ufr_next, dfr_reg, dfr_next, ui_reg, ui_next;
    fome_pkg::count_t    k_reg, k_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                ov_reg, ov_next;
    logic                oacc_reg, oacc_next, oup_reg, oup_next, odn_reg, odn_next;
    logic signed [1:0]   osign_reg, osign_next, odc_reg, odc_next;
    logic [6:0]          ocnt_reg, ocnt_next;

    // ---------------- list memories ----------------
    logic                ram_we    [fome_pkg::NUM_LISTS];
    fome_pkg::site_t     ram_waddr [fome_pkg::NUM_LISTS];
    fome_pkg::site_t     ram_wdata [fome_pkg::NUM_LISTS];
    fome_pkg::site_t     ram_raddr [fome_pkg::NUM_LISTS];
    fome_pkg::site_t     ram_rdata [fome_pkg::NUM_LISTS];

    for (genvar g = 0; g < fome_pkg::NUM_LISTS; g++)
    begin : g_list
        fome_ram #(
            .WIDTH (fome_pkg::SITE_W),
            .DEPTH (fome_pkg::MAX_SITES)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_waddr[g]),
            .wdata (ram_wdata[g]),
            .raddr (ram_raddr[g]),
            .rdata (ram_rdata[g])
        );
    end

    function automatic fome_pkg::occ_t onehot(input fome_pkg::site_t s);
        return fome_pkg::occ_t'(1) << s;
    endfunction

    // sites strictly below s
    function automatic fome_pkg::occ_t below(input fome_pkg::site_t s);
        return (fome_pkg::occ_t'(1) << s) - fome_pkg::occ_t'(1);
    endfunction

    // ---------------- undo of the pending move ----------------
    fome_pkg::occ_t up_u, dn_u;
    always_comb
    begin
        up_u = up_reg;
        dn_u = dn_reg;
        if (kind_reg == fome_pkg::KIND_UP || kind_reg == fome_pkg::KIND_EX)
        begin
            up_u = (up_u | onehot(ms_reg[0])) & ~onehot(ms_reg[1]);
        end
        if (kind_reg == fome_pkg::KIND_DN)
        begin
            dn_u = (dn_u | onehot(ms_reg[0])) & ~onehot(ms_reg[1]);
        end
        if (kind_reg == fome_pkg::KIND_EX)
        begin
            dn_u = (dn_u | onehot(ms_reg[2])) & ~onehot(ms_reg[3]);
        end
    end

    // committed count plus pending change, saturated
    logic signed [8:0] dsum;
    logic [6:0]        dsat;
    assign dsum = $signed({2'b00, dtot_reg}) + 9'(pdc_reg);
    assign dsat = (dsum < 0) ? 7'd0 : ((dsum > 9'sd127) ? 7'd127 : dsum[6:0]);

    // ---------------- hop proposal ----------------
    logic              hp_dn, hp_ok;
    fome_pkg::occ_t    hp_b, hp_o;
    fome_pkg::site_t   hp_fr, hp_to, hp_pick;
    fome_pkg::count_t  hp_cnt, hp_holes;
    assign hp_dn    = (op_reg == fome_pkg::OP_DN_HOP);
    assign hp_b     = hp_dn ? dn_reg : up_reg;
    assign hp_o     = hp_dn ? up_reg : dn_reg;
    assign hp_fr    = hp_dn ? ram_rdata[fome_pkg::LIST_DN_PART] : ram_rdata[fome_pkg::LIST_UP_PART];
    assign hp_to    = hp_dn ? ram_rdata[fome_pkg::LIST_DN_HOLE] : ram_rdata[fome_pkg::LIST_UP_HOLE];
    assign hp_pick  = hp_dn ? dpk_reg : upk_reg;
    assign hp_cnt   = hp_dn ? dc_w : uc_w;
    assign hp_holes = hp_dn ? dh_w : uh_w;
    assign hp_ok    = (hp_cnt != '0) && (hp_holes != '0)
                      && ({1'b0, hp_pick} < hp_cnt) && ({1'b0, hpk_reg} < hp_holes)
                      && ({1'b0, hp_fr} < n_w) && ({1'b0, hp_to} < n_w)
                      && (ad_reg || !hp_o[hp_to]);

    // ---------------- hop operator ----------------
    logic              ho_dn, ho_rng, ho_fwd, ho_rev, ho_par;
    fome_pkg::occ_t    ho_b, ho_o;
    fome_pkg::site_t   ho_fr, ho_to, ho_lo, ho_hi;
    assign ho_dn  = (op_reg == fome_pkg::OP_DN_OPR);
    assign ho_b   = ho_dn ? dn_reg : up_reg;
    assign ho_o   = ho_dn ? up_reg : dn_reg;
    assign ho_rng = ({1'b0, si_reg} < n_w) && ({1'b0, sj_reg} < n_w);
    assign ho_fwd = ho_b[si_reg] && !ho_b[sj_reg];
    assign ho_rev = !ho_b[si_reg] && ho_b[sj_reg];
    assign ho_fr  = ho_rev ? sj_reg : si_reg;
    assign ho_to  = ho_rev ? si_reg : sj_reg;
    assign ho_lo  = (ho_fr < ho_to) ? ho_fr : ho_to;
    assign ho_hi  = (ho_fr < ho_to) ? ho_to : ho_fr;
    // endpoints excluded, so the pre-change bits give the same parity
    assign ho_par = ^(ho_b & below(ho_hi) & ~(below(ho_lo) | onehot(ho_lo)));

    // ---------------- exchange operator ----------------
    logic              xo_c1, xo_c2, xo_par;
    fome_pkg::site_t   xo_uf, xo_ut, xo_lo, xo_hi;
    fome_pkg::occ_t    xo_up, xo_dn;
    assign xo_c1  = up_reg[si_reg] && !up_reg[sj_reg] && !dn_reg[si_reg] && dn_reg[sj_reg];
    assign xo_c2  = !up_reg[si_reg] && up_reg[sj_reg] && dn_reg[si_reg] && !dn_reg[sj_reg];
    assign xo_uf  = xo_c1 ? si_reg : sj_reg;
    assign xo_ut  = xo_c1 ? sj_reg : si_reg;
    assign xo_up  = (up_reg & ~onehot(xo_uf)) | onehot(xo_ut);
    assign xo_dn  = (dn_reg & ~onehot(xo_ut)) | onehot(xo_uf);
    assign xo_lo  = (xo_uf < xo_ut) ? xo_uf : xo_ut;
    assign xo_hi  = (xo_uf < xo_ut) ? xo_ut : xo_uf;
    assign xo_par = ^((xo_up ^ xo_dn) & below(xo_hi) & ~below(xo_lo));

    // ---------------- double-occupancy recount slice ----------------
    fome_pkg::occ_t dbl_w;
    logic [7:0]     dbl_slice;
    logic [3:0]     dbl_pop;
    assign dbl_w     = up_reg & dn_reg & ((fome_pkg::occ_t'(1) << n_w) - fome_pkg::occ_t'(1));
    assign dbl_slice = dbl_w[{cnt_reg, 3'b000} +: 8];
    always_comb
    begin
        dbl_pop = '0;
        for (int b = 0; b < 8; b++)
        begin
            dbl_pop = dbl_pop + 4'(dbl_slice[b]);
        end
    end

    fome_pkg::count_t k_inc;
    assign k_inc = k_reg + fome_pkg::count_t'(1);

    assign req.ready = (state_reg == S_IDLE);

    // ---------------- next-state logic ----------------
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;   upk_next = upk_reg;   dpk_next = dpk_reg;
        hpk_next = hpk_reg; si_next = si_reg;     sj_next = sj_reg;
        sel_next = sel_reg; lidx_next = lidx_reg; lsite_next = lsite_reg;
        up_next = up_reg;   dn_next = dn_reg;     kind_next = kind_reg;
        ms_next = ms_reg;   mi_next = mi_reg;     pdc_next = pdc_reg;
        dtot_next = dtot_reg; acc_next = acc_reg; sign_next = sign_reg;
        ufr_next = ufr_reg; dfr_next = dfr_reg;   ui_next = ui_reg;
        k_next = k_reg;     cnt_next = cnt_reg;
        ov_next = ov_reg;   oacc_next = oacc_reg; osign_next = osign_reg;
        odc_next = odc_reg; ocnt_next = ocnt_reg; oup_next = oup_reg; odn_next = odn_reg;
        for (int l = 0; l < fome_pkg::NUM_LISTS; l++)
        begin
            ram_we[l]    = 1'b0;
            ram_waddr[l] = '0;
            ram_wdata[l] = '0;
            ram_raddr[l] = '0;
        end

        // result taken
        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    upk_next   = req.up_pick;
                    dpk_next   = req.down_pick;
                    hpk_next   = req.hole_pick;
                    si_next    = req.site_i;
                    sj_next    = req.site_j;
                    sel_next   = req.list_select;
                    lidx_next  = req.list_index;
                    lsite_next = req.list_site;
                    acc_next   = 1'b0;
                    sign_next  = fome_pkg::SIGN_ZERO;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                // list reads for proposals
                ram_raddr[fome_pkg::LIST_UP_PART] = upk_reg;
                ram_raddr[fome_pkg::LIST_UP_HOLE] = hpk_reg;
                ram_raddr[fome_pkg::LIST_DN_PART] = dpk_reg;
                ram_raddr[fome_pkg::LIST_DN_HOLE] = hpk_reg;
                state_next = S_DONE;
                if (op_reg == fome_pkg::OP_CLEAR)
                begin
                    up_next   = '0;
                    dn_next   = '0;
                    kind_next = fome_pkg::KIND_NONE;
                    pdc_next  = '0;
                    dtot_next = '0;
                    for (int m = 0; m < 4; m++)
                    begin
                        ms_next[m] = '0;
                        mi_next[m] = '0;
                    end
                end
                else if (op_reg == fome_pkg::OP_COMMIT)
                begin
                    if (kind_reg == fome_pkg::KIND_UP || kind_reg == fome_pkg::KIND_EX)
                    begin
                        ram_we[fome_pkg::LIST_UP_PART]    = 1'b1;
                        ram_waddr[fome_pkg::LIST_UP_PART] = mi_reg[0];
                        ram_wdata[fome_pkg::LIST_UP_PART] = ms_reg[1];
                        ram_we[fome_pkg::LIST_UP_HOLE]    = 1'b1;
                        ram_waddr[fome_pkg::LIST_UP_HOLE] = mi_reg[1];
                        ram_wdata[fome_pkg::LIST_UP_HOLE] = ms_reg[0];
                    end
                    if (kind_reg == fome_pkg::KIND_DN)
                    begin
                        ram_we[fome_pkg::LIST_DN_PART]    = 1'b1;
                        ram_waddr[fome_pkg::LIST_DN_PART] = mi_reg[0];
                        ram_wdata[fome_pkg::LIST_DN_PART] = ms_reg[1];
                        ram_we[fome_pkg::LIST_DN_HOLE]    = 1'b1;
                        ram_waddr[fome_pkg::LIST_DN_HOLE] = mi_reg[1];
                        ram_wdata[fome_pkg::LIST_DN_HOLE] = ms_reg[0];
                    end
                    if (kind_reg == fome_pkg::KIND_EX)
                    begin
                        ram_we[fome_pkg::LIST_DN_PART]    = 1'b1;
                        ram_waddr[fome_pkg::LIST_DN_PART] = mi_reg[2];
                        ram_wdata[fome_pkg::LIST_DN_PART] = ms_reg[3];
                        ram_we[fome_pkg::LIST_DN_HOLE]    = 1'b1;
                        ram_waddr[fome_pkg::LIST_DN_HOLE] = mi_reg[3];
                        ram_wdata[fome_pkg::LIST_DN_HOLE] = ms_reg[2];
                    end
                    if (kind_reg == fome_pkg::KIND_UP || kind_reg == fome_pkg::KIND_DN)
                    begin
                        dtot_next = dsat;
                    end
                    kind_next = fome_pkg::KIND_NONE;
                    pdc_next  = '0;
                end
                else if (op_reg >= fome_pkg::OP_LOAD && op_reg <= fome_pkg::OP_UNDO)
                begin
                    // every other known op except query first undoes the pending move
                    up_next   = up_u;
                    dn_next   = dn_u;
                    kind_next = fome_pkg::KIND_NONE;
                    pdc_next  = '0;
                    if (op_reg == fome_pkg::OP_LOAD)
                    begin
                        if ({1'b0, lsite_reg} < n_w)
                        begin
                            ram_we[sel_reg]    = 1'b1;
                            ram_waddr[sel_reg] = lidx_reg;
                            ram_wdata[sel_reg] = lsite_reg;
                            if (sel_reg == fome_pkg::LIST_UP_PART)
                            begin
                                up_next = up_u | onehot(lsite_reg);
                            end
                            if (sel_reg == fome_pkg::LIST_DN_PART)
                            begin
                                dn_next = dn_u | onehot(lsite_reg);
                            end
                            dtot_next  = '0;
                            cnt_next   = '0;
                            state_next = S_COUNT;
                        end
                    end
                    else if (op_reg == fome_pkg::OP_UP_HOP || op_reg == fome_pkg::OP_DN_HOP)
                    begin
                        state_next = S_HOP;
                    end
                    else if (op_reg == fome_pkg::OP_EXCH)
                    begin
                        state_next = S_EXRD;
                    end
                    else if (op_reg != fome_pkg::OP_UNDO)
                    begin
                        state_next = S_OP;
                    end
                end
            end

            S_HOP:
            begin
                if (hp_ok)
                begin
                    if (hp_dn)
                    begin
                        dn_next   = (hp_b & ~onehot(hp_fr)) | onehot(hp_to);
                        kind_next = fome_pkg::KIND_DN;
                    end
                    else
                    begin
                        up_next   = (hp_b & ~onehot(hp_fr)) | onehot(hp_to);
                        kind_next = fome_pkg::KIND_UP;
                    end
                    pdc_next   = {1'b0, hp_o[hp_to]} - {1'b0, hp_o[hp_fr]};
                    ms_next[0] = hp_fr;
                    ms_next[1] = hp_to;
                    mi_next[0] = hp_pick;
                    mi_next[1] = hpk_reg;
                    acc_next   = 1'b1;
                end
                state_next = S_DONE;
            end

            S_EXRD:
            begin
                state_next = S_DONE;
                if (uc_w != '0 && uh_w != '0 && dc_w != '0 && dh_w != '0
                    && {1'b0, upk_reg} < uc_w && {1'b0, dpk_reg} < dc_w
                    && {1'b0, ram_rdata[fome_pkg::LIST_UP_PART]} < n_w
                    && {1'b0, ram_rdata[fome_pkg::LIST_DN_PART]} < n_w)
                begin
                    ufr_next   = ram_rdata[fome_pkg::LIST_UP_PART];
                    dfr_next   = ram_rdata[fome_pkg::LIST_DN_PART];
                    k_next     = '0;
                    ram_raddr[fome_pkg::LIST_UP_HOLE] = '0;
                    state_next = S_EXS1;
                end
            end

            // search up holes for the down particle's site
            S_EXS1:
            begin
                if (k_reg >= uh_w)
                begin
                    state_next = S_DONE;
                end
                else if (ram_rdata[fome_pkg::LIST_UP_HOLE] == dfr_reg)
                begin
                    ui_next    = k_reg[fome_pkg::SITE_W-1:0];
                    k_next     = '0;
                    ram_raddr[fome_pkg::LIST_DN_HOLE] = '0;
                    state_next = S_EXS2;
                end
                else
                begin
                    k_next = k_inc;
                    ram_raddr[fome_pkg::LIST_UP_HOLE] = k_inc[fome_pkg::SITE_W-1:0];
                end
            end

            // search down holes for the up particle's site
            S_EXS2:
            begin
                if (k_reg >= dh_w)
                begin
                    state_next = S_DONE;
                end
                else if (ram_rdata[fome_pkg::LIST_DN_HOLE] == ufr_reg)
                begin
                    up_next    = (up_reg & ~onehot(ufr_reg)) | onehot(dfr_reg);
                    dn_next    = (dn_reg & ~onehot(dfr_reg)) | onehot(ufr_reg);
                    kind_next  = fome_pkg::KIND_EX;
                    ms_next[0] = ufr_reg;
                    ms_next[1] = dfr_reg;
                    ms_next[2] = dfr_reg;
                    ms_next[3] = ufr_reg;
                    mi_next[0] = upk_reg;
                    mi_next[1] = ui_reg;
                    mi_next[2] = dpk_reg;
                    mi_next[3] = k_reg[fome_pkg::SITE_W-1:0];
                    acc_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_inc;
                    ram_raddr[fome_pkg::LIST_DN_HOLE] = k_inc[fome_pkg::SITE_W-1:0];
                end
            end

            S_OP:
            begin
                state_next = S_DONE;
                if (!ho_rng)
                begin
                    sign_next = fome_pkg::SIGN_ZERO;
                end
                else if (op_reg == fome_pkg::OP_EX_OPR)
                begin
                    if (si_reg == sj_reg)
                    begin
                        sign_next = fome_pkg::SIGN_POS;
                    end
                    else if (xo_c1 || xo_c2)
                    begin
                        up_next    = xo_up;
                        dn_next    = xo_dn;
                        kind_next  = fome_pkg::KIND_EX;
                        ms_next[0] = xo_uf;
                        ms_next[1] = xo_ut;
                        ms_next[2] = xo_ut;
                        ms_next[3] = xo_uf;
                        acc_next   = 1'b1;
                        sign_next  = xo_par ? fome_pkg::SIGN_NEG : fome_pkg::SIGN_POS;
                    end
                end
                else if (ho_fwd || ho_rev)
                begin
                    if (ho_dn)
                    begin
                        dn_next   = (ho_b & ~onehot(ho_fr)) | onehot(ho_to);
                        kind_next = fome_pkg::KIND_DN;
                    end
                    else
                    begin
                        up_next   = (ho_b & ~onehot(ho_fr)) | onehot(ho_to);
                        kind_next = fome_pkg::KIND_UP;
                    end
                    pdc_next   = {1'b0, ho_o[ho_to]} - {1'b0, ho_o[ho_fr]};
                    ms_next[0] = ho_fr;
                    ms_next[1] = ho_to;
                    acc_next   = 1'b1;
                    sign_next  = ho_par ? fome_pkg::SIGN_NEG : fome_pkg::SIGN_POS;
                end
            end

            S_COUNT:
            begin
                dtot_next = dtot_reg + 7'(dbl_pop);
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    oacc_next  = acc_reg;
                    osign_next = sign_reg;
                    odc_next   = pdc_reg;
                    ocnt_next  = dtot_reg;
                    oup_next   = ({1'b0, si_reg} < n_w) && up_reg[si_reg];
                    odn_next   = ({1'b0, si_reg} < n_w) && dn_reg[si_reg];
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- state and output registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= '0;   upk_reg <= '0; dpk_reg <= '0; hpk_reg <= '0;
            si_reg <= '0;   sj_reg <= '0;  sel_reg <= '0; lidx_reg <= '0; lsite_reg <= '0;
            up_reg <= '0;   dn_reg <= '0;  kind_reg <= fome_pkg::KIND_NONE;
            for (int m = 0; m < 4; m++)
            begin
                ms_reg[m] <= '0;
                mi_reg[m] <= '0;
            end
            pdc_reg <= '0;  dtot_reg <= '0; acc_reg <= 1'b0; sign_reg <= '0;
            ufr_reg <= '0;  dfr_reg <= '0;  ui_reg <= '0;   k_reg <= '0; cnt_reg <= '0;
            ov_reg <= 1'b0; oacc_reg <= 1'b0; osign_reg <= '0; odc_reg <= '0;
            ocnt_reg <= '0; oup_reg <= 1'b0; odn_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;   upk_reg <= upk_next; dpk_reg <= dpk_next;
            hpk_reg <= hpk_next; si_reg <= si_next;   sj_reg <= sj_next;
            sel_reg <= sel_next; lidx_reg <= lidx_next; lsite_reg <= lsite_next;
            up_reg <= up_next;   dn_reg <= dn_next;   kind_reg <= kind_next;
            ms_reg <= ms_next;   mi_reg <= mi_next;
            pdc_reg <= pdc_next; dtot_reg <= dtot_next; acc_reg <= acc_next;
            sign_reg <= sign_next;
            ufr_reg <= ufr_next; dfr_reg <= dfr_next; ui_reg <= ui_next;
            k_reg <= k_next;     cnt_reg <= cnt_next;
            ov_reg <= ov_next;   oacc_reg <= oacc_next; osign_reg <= osign_next;
            odc_reg <= odc_next; ocnt_reg <= ocnt_next; oup_reg <= oup_next;
            odn_reg <= odn_next;
        end
    end

    assign rsp.valid         = ov_reg;
    assign rsp.accepted      = oacc_reg;
    assign rsp.sign          = osign_reg;
    assign rsp.double_change = odc_reg;
    assign rsp.double_count  = ocnt_reg;
    assign rsp.up_occupied   = oup_reg;
    assign rsp.down_occupied = odn_reg;

    // ---------------- assertions ----------------
    `FOME_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `FOME_ASSERT_ALWAYS(a_no_change_without_move,
        kind_reg != fome_pkg::KIND_NONE || pdc_reg == 2'sb00)
    `FOME_ASSERT_IMPLIES(a_hole_search_bound,
        state_reg == S_EXS1 || state_reg == S_EXS2,
        k_reg <= fome_pkg::count_t'(fome_pkg::MAX_SITES))

endmodule

`default_nettype wire
